[rtl/awts_pkg.sv]
package awts_pkg;

    localparam int CordSteps = 30;
    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 36;

    // Stage counts of the item pipeline and the delay lines that align with it.
    localparam int PipeDepth = 108;
    localparam int ZeroDly   = 107;
    localparam int CarryDly  = 105;
    localparam int DistDly   = 73;
    localparam int Sn2Dly    = 33;
    localparam int YawDly    = 34;

    // Angles are signed radians in Q.30.
    localparam logic signed [35:0] AngPi    = 36'sd3373259426;
    localparam logic signed [35:0] AngTwoPi = 36'sd6746518852;

    typedef enum logic [2:0] {
        CFG_CAM_POS_X  = 3'd0,
        CFG_CAM_POS_Y  = 3'd1,
        CFG_CAM_POS_Z  = 3'd2,
        CFG_LOOK_DIR_X = 3'd3,
        CFG_LOOK_DIR_Y = 3'd4,
        CFG_LOOK_DIR_Z = 3'd5,
        CFG_HORIZ_FOV  = 3'd6,
        CFG_ASPECT     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [35:0] z;
        logic               zero;
    } t_cord;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sqrt;

    typedef struct packed {
        logic [35:0] q;
        logic [13:0] r;
    } t_div;

    function automatic logic [35:0] atan_q30(input logic [4:0] step);
        logic [35:0] a;
        case (step)
            5'd0:  a = 36'd843314856;
            5'd1:  a = 36'd497837829;
            5'd2:  a = 36'd263043836;
            5'd3:  a = 36'd133525158;
            5'd4:  a = 36'd67021686;
            5'd5:  a = 36'd33543515;
            5'd6:  a = 36'd16775850;
            5'd7:  a = 36'd8388437;
            5'd8:  a = 36'd4194282;
            5'd9:  a = 36'd2097149;
            5'd10: a = 36'd1048575;
            5'd11: a = 36'd524287;
            5'd12: a = 36'd262143;
            5'd13: a = 36'd131071;
            5'd14: a = 36'd65535;
            5'd15: a = 36'd32767;
            5'd16: a = 36'd16383;
            5'd17: a = 36'd8191;
            5'd18: a = 36'd4095;
            5'd19: a = 36'd2047;
            5'd20: a = 36'd1023;
            5'd21: a = 36'd511;
            5'd22: a = 36'd255;
            5'd23: a = 36'd127;
            5'd24: a = 36'd63;
            5'd25: a = 36'd31;
            5'd26: a = 36'd15;
            5'd27: a = 36'd8;
            5'd28: a = 36'd4;
            5'd29: a = 36'd2;
            default: a = 36'd0;
        endcase
        return a;
    endfunction

    // Folds a vector into the right half plane before the rotations.
    function automatic t_cord cordic_pre(input logic signed [33:0] x,
                                         input logic signed [33:0] y);
        t_cord c;
        c.zero = (x == 34'sd0) && (y == 34'sd0);
        c.x = x;
        c.y = y;
        c.z = 36'sd0;
        if (x < 34'sd0) begin
            c.z = (y >= 34'sd0) ? AngPi : -AngPi;
            c.x = -x;
            c.y = -y;
        end
        return c;
    endfunction

    function automatic logic signed [33:0] cordic_post(input t_cord c);
        logic signed [35:0] z;
        z = c.z;
        if (z > AngPi) begin
            z = z - AngTwoPi;
        end else if (z <= -AngPi) begin
            z = z + AngTwoPi;
        end
        if (c.zero) begin
            z = 36'sd0;
        end
        return z[33:0];
    endfunction

    function automatic logic signed [33:0] wrap_diff(input logic signed [34:0] d);
        logic signed [35:0] z;
        z = 36'(d);
        if (z > AngPi) begin
            z = z - AngTwoPi;
        end else if (z <= -AngPi) begin
            z = z + AngTwoPi;
        end
        return z[33:0];
    endfunction

    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // Brings a magnitude to the common scale where the largest one has its top bit at 29.
    function automatic logic [29:0] norm_mag(input logic [31:0] v, input logic [4:0] p);
        logic [31:0] t;
        if (p >= 5'd30) begin
            t = v >> (p - 5'd29);
        end else begin
            t = v << (5'd29 - p);
        end
        return t[29:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] s;
        if (v > 37'sd2147483647) begin
            s = 32'h7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

endpackage

[rtl/awts_cordic_cell.sv]
module awts_cordic_cell
    import awts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_cord      i_d,
    output t_cord      o_d
);

    t_cord              r_d;
    t_cord              n_d;
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;

    always_comb begin
        w_xs = i_d.x >>> i_step;
        w_ys = i_d.y >>> i_step;
        n_d  = i_d;
        if (i_d.y > 34'sd0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + $signed(atan_q30(i_step));
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - $signed(atan_q30(i_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[rtl/awts_sqrt_cell.sv]
module awts_sqrt_cell
    import awts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_sqrt      i_d,
    output t_sqrt      o_d
);

    t_sqrt       r_d;
    t_sqrt       n_d;
    logic [63:0] w_bit;
    logic [64:0] w_t;

    // One result bit per cell, trial bit moving down two places each step.
    always_comb begin
        w_bit = 64'd1 << (6'd62 - {i_step, 1'b0});
        w_t   = {1'b0, i_d.r} + {1'b0, w_bit};
        n_d   = i_d;
        if ({1'b0, i_d.v} >= w_t) begin
            n_d.v = i_d.v - w_t[63:0];
            n_d.r = (i_d.r >> 1) + w_bit;
        end else begin
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[rtl/awts_div_cell.sv]
module awts_div_cell
    import awts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [13:0] i_den,
    input  t_div        i_d,
    output t_div        o_d
);

    t_div        r_d;
    t_div        n_d;
    logic [14:0] w_rs;

    // Restoring division: the dividend shifts out of q while quotient bits shift in.
    always_comb begin
        w_rs    = {i_d.r, i_d.q[35]};
        n_d.q   = {i_d.q[34:0], 1'b0};
        n_d.r   = w_rs[13:0];
        if (w_rs >= {1'b0, i_den}) begin
            n_d.r    = 14'(w_rs - {1'b0, i_den});
            n_d.q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[rtl/angular_world_to_screen.sv]
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_ready       i_obj_x, i_obj_y, i_obj_z
// output    out        o_valid / i_ready       o_screen_x, o_screen_y, o_distance,
//                                              o_at_camera
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while no result is held at the output.
// Each item passes offset and scaling stages, a 32-cell square root, a 30-cell CORDIC
// chain and a 36-cell divider in series; the 30-cell yaw CORDIC runs beside the root.
// Camera angles come from a free-running chain and settle once a config write passes it.
// Reset is synchronous, active low; it empties the pipeline and loads the config defaults.
// A held result freezes the whole item pipeline, and o_ready stays high otherwise.
module angular_world_to_screen
    import awts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_obj_x,
    input  logic [31:0] i_obj_y,
    input  logic [31:0] i_obj_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_screen_x,
    output logic [31:0] o_screen_y,
    output logic [31:0] o_distance,
    output logic        o_at_camera,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_look_x, r_look_y, r_look_z;
    logic [13:0]        r_fov;
    logic [14:0]        r_aspect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x  <= 32'sd0;
            r_cam_y  <= 32'sd0;
            r_cam_z  <= 32'sd0;
            r_look_x <= 16'sd16384;
            r_look_y <= 16'sd0;
            r_look_z <= 16'sd0;
            r_fov    <= 14'd5004;
            r_aspect <= 15'd5461;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAM_POS_X:  r_cam_x  <= i_cfg_data;
                CFG_CAM_POS_Y:  r_cam_y  <= i_cfg_data;
                CFG_CAM_POS_Z:  r_cam_z  <= i_cfg_data;
                CFG_LOOK_DIR_X: r_look_x <= i_cfg_data[15:0];
                CFG_LOOK_DIR_Y: r_look_y <= i_cfg_data[15:0];
                CFG_LOOK_DIR_Z: r_look_z <= i_cfg_data[15:0];
                CFG_HORIZ_FOV:  r_fov    <= i_cfg_data[13:0];
                CFG_ASPECT:     r_aspect <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [13:0] w_f;
    logic [14:0] w_a;
    assign w_f = (r_fov == 14'd0) ? 14'd1 : r_fov;
    assign w_a = (r_aspect == 15'd0) ? 15'd1 : r_aspect;

    // ---------------- camera angle chain (free running) ----------------
    logic [15:0]        w_lmx, w_lmy;
    logic [4:0]         w_lmsb;
    logic [29:0]        w_lnx, w_lny;
    logic signed [33:0] w_lsx, w_lsy;
    logic signed [31:0] w_lz2;
    logic signed [32:0] w_rem;
    t_cord              r_cy;
    logic [63:0]        r_cp_v;
    t_cord              r_cp_pre;
    logic signed [33:0] r_cam_yaw, r_cam_elev;
    t_cord              w_cyc [0:CordSteps];
    t_cord              w_cpc [0:CordSteps];
    t_sqrt              w_cps [0:SqrtSteps];

    always_comb begin
        w_lmx  = r_look_x[15] ? 16'(-r_look_x) : r_look_x;
        w_lmy  = r_look_y[15] ? 16'(-r_look_y) : r_look_y;
        w_lmsb = msb_pos({16'd0, w_lmx | w_lmy});
        w_lnx  = norm_mag({16'd0, w_lmx}, w_lmsb);
        w_lny  = norm_mag({16'd0, w_lmy}, w_lmsb);
        w_lsx  = r_look_x[15] ? -$signed({4'd0, w_lnx}) : $signed({4'd0, w_lnx});
        w_lsy  = r_look_y[15] ? -$signed({4'd0, w_lny}) : $signed({4'd0, w_lny});
        w_lz2  = r_look_z * r_look_z;
        w_rem  = 33'sd268435456 - 33'(w_lz2);
    end

    always_ff @(posedge i_clk) begin
        r_cy        <= cordic_pre(w_lsx, w_lsy);
        r_cp_v      <= (w_rem < 33'sd0) ? 64'd0 : {7'd0, w_rem[28:0], 28'd0};
        r_cp_pre    <= cordic_pre($signed(w_cps[SqrtSteps].r[33:0]),
                                  34'(r_look_z) <<< 14);
        r_cam_yaw   <= cordic_post(w_cyc[CordSteps]);
        r_cam_elev  <= cordic_post(w_cpc[CordSteps]);
    end

    assign w_cyc[0] = r_cy;
    assign w_cps[0] = '{v: r_cp_v, r: 64'd0};
    assign w_cpc[0] = r_cp_pre;

    // ---------------- item pipeline ----------------
    logic w_en, w_acc;
    logic r_vld [0:PipeDepth-1];
    logic r_ovalid;

    assign w_en    = !r_ovalid || i_ready;
    assign w_acc   = i_valid && w_en;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PipeDepth; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= w_acc;
            for (int k = 1; k < PipeDepth; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovalid <= r_vld[PipeDepth-1];
        end
    end

    logic signed [32:0] r_a_d [0:2];
    logic               r_a_zero;
    logic [31:0]        w_mag [0:2];
    logic [63:0]        r_b_sq [0:2];
    logic [31:0]        r_b_mag [0:2];
    logic               r_b_neg [0:2];
    logic [4:0]         r_b_msb;
    logic [65:0]        w_sum;
    logic [63:0]        r_c_sum;
    logic               r_c_carry;
    logic [29:0]        r_c_nm [0:2];
    logic               r_c_neg [0:2];
    logic signed [33:0] w_sn [0:2];
    logic [59:0]        r_d_nsq0, r_d_nsq1;
    t_cord              r_d_yaw;
    logic signed [33:0] r_d_sn2;
    logic [60:0]        r_e_hsum;
    logic signed [33:0] r_yaw;
    t_cord              r_p_pre;
    logic signed [33:0] r_pitch;
    logic signed [33:0] r_ry, r_ry2;
    logic signed [34:0] r_rp;
    logic signed [50:0] r_prod;
    logic signed [36:0] w_nx;
    logic signed [34:0] w_nx4;
    logic signed [51:0] w_ny;
    logic signed [37:0] w_ny14;
    logic [35:0]        r_mx, r_my;
    logic               r_negx, r_negy;

    logic               r_zdly   [0:ZeroDly-1];
    logic               r_cdly   [0:CarryDly-1];
    logic [31:0]        r_ddly   [0:DistDly-1];
    logic signed [33:0] r_sdly   [0:Sn2Dly-1];
    logic signed [33:0] r_ydly   [0:YawDly-1];
    logic               r_nxdly  [0:DivSteps-1];
    logic               r_nydly  [0:DivSteps-1];

    t_sqrt w_dsq [0:SqrtSteps];
    t_sqrt w_hsq [0:SqrtSteps];
    t_cord w_yc  [0:CordSteps];
    t_cord w_pc  [0:CordSteps];
    t_div  w_dvx [0:DivSteps];
    t_div  w_dvy [0:DivSteps];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_a_d[i][32] ? 32'(-r_a_d[i]) : r_a_d[i][31:0];
            w_sn[i]  = r_c_neg[i] ? -$signed({4'd0, r_c_nm[i]})
                                  : $signed({4'd0, r_c_nm[i]});
        end
        w_sum  = {2'd0, r_b_sq[0]} + {2'd0, r_b_sq[1]} + {2'd0, r_b_sq[2]};
        // Rounding offsets fold into the floor division by fov.
        w_nx   = $signed({6'd0, w_f, 17'd0}) + $signed({22'd0, w_f, 1'b0}) - 37'(r_ry2);
        w_nx4  = 35'(w_nx >>> 2);
        w_ny   = 52'(r_prod) + $signed({9'd0, w_f, 29'd0}) + $signed({25'd0, w_f, 13'd0});
        w_ny14 = 38'(w_ny >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d[0] <= $signed({i_obj_x[31], i_obj_x}) - 33'(r_cam_x);
            r_a_d[1] <= $signed({i_obj_y[31], i_obj_y}) - 33'(r_cam_y);
            r_a_d[2] <= $signed({i_obj_z[31], i_obj_z}) - 33'(r_cam_z);
            r_a_zero <= (i_obj_x == r_cam_x) && (i_obj_y == r_cam_y) && (i_obj_z == r_cam_z);

            for (int i = 0; i < 3; i++) begin
                r_b_sq[i]  <= 64'(w_mag[i]) * 64'(w_mag[i]);
                r_b_mag[i] <= w_mag[i];
                r_b_neg[i] <= r_a_d[i][32];
                r_c_nm[i]  <= norm_mag(r_b_mag[i], r_b_msb);
                r_c_neg[i] <= r_b_neg[i];
            end
            r_b_msb   <= msb_pos(w_mag[0] | w_mag[1] | w_mag[2]);
            r_c_sum   <= w_sum[63:0];
            r_c_carry <= |w_sum[65:64];

            r_d_nsq0 <= 60'(r_c_nm[0]) * 60'(r_c_nm[0]);
            r_d_nsq1 <= 60'(r_c_nm[1]) * 60'(r_c_nm[1]);
            r_d_yaw  <= cordic_pre(w_sn[0], w_sn[1]);
            r_d_sn2  <= w_sn[2];
            r_e_hsum <= {1'b0, r_d_nsq0} + {1'b0, r_d_nsq1};

            r_yaw   <= cordic_post(w_yc[CordSteps]);
            r_p_pre <= cordic_pre($signed(w_hsq[SqrtSteps].r[33:0]), r_sdly[Sn2Dly-1]);
            r_pitch <= cordic_post(w_pc[CordSteps]);

            r_ry   <= wrap_diff(35'(r_ydly[YawDly-1]) - 35'(r_cam_yaw));
            r_rp   <= 35'(r_cam_elev) - 35'(r_pitch);
            r_ry2  <= r_ry;
            r_prod <= r_rp * $signed({1'b0, w_a});

            // Floor division of a negative value goes through its complement.
            r_negx <= w_nx4[34];
            r_mx   <= w_nx4[34] ? {1'b0, ~w_nx4} : {1'b0, w_nx4};
            r_negy <= w_ny14[37];
            r_my   <= w_ny14[37] ? 36'(~w_ny14) : w_ny14[35:0];

            r_zdly[0]  <= r_a_zero;
            r_cdly[0]  <= r_c_carry;
            r_ddly[0]  <= w_dsq[SqrtSteps].r[31:0];
            r_sdly[0]  <= r_d_sn2;
            r_ydly[0]  <= r_yaw;
            r_nxdly[0] <= r_negx;
            r_nydly[0] <= r_negy;
            for (int k = 1; k < ZeroDly; k++)  r_zdly[k]  <= r_zdly[k-1];
            for (int k = 1; k < CarryDly; k++) r_cdly[k]  <= r_cdly[k-1];
            for (int k = 1; k < DistDly; k++)  r_ddly[k]  <= r_ddly[k-1];
            for (int k = 1; k < Sn2Dly; k++)   r_sdly[k]  <= r_sdly[k-1];
            for (int k = 1; k < YawDly; k++)   r_ydly[k]  <= r_ydly[k-1];
            for (int k = 1; k < DivSteps; k++) r_nxdly[k] <= r_nxdly[k-1];
            for (int k = 1; k < DivSteps; k++) r_nydly[k] <= r_nydly[k-1];
        end
    end

    assign w_dsq[0] = '{v: r_c_sum, r: 64'd0};
    assign w_hsq[0] = '{v: {3'd0, r_e_hsum}, r: 64'd0};
    assign w_yc[0]  = r_d_yaw;
    assign w_pc[0]  = r_p_pre;
    assign w_dvx[0] = '{q: r_mx, r: 14'd0};
    assign w_dvy[0] = '{q: r_my, r: 14'd0};

    genvar g;
    generate
        for (g = 0; g < CordSteps; g++) begin : g_cord
            awts_cordic_cell u_cam_yaw (
                .i_clk(i_clk), .i_en(1'b1), .i_step(5'(g)),
                .i_d(w_cyc[g]), .o_d(w_cyc[g+1])
            );
            awts_cordic_cell u_cam_elev (
                .i_clk(i_clk), .i_en(1'b1), .i_step(5'(g)),
                .i_d(w_cpc[g]), .o_d(w_cpc[g+1])
            );
            awts_cordic_cell u_obj_yaw (
                .i_clk(i_clk), .i_en(w_en), .i_step(5'(g)),
                .i_d(w_yc[g]), .o_d(w_yc[g+1])
            );
            awts_cordic_cell u_obj_elev (
                .i_clk(i_clk), .i_en(w_en), .i_step(5'(g)),
                .i_d(w_pc[g]), .o_d(w_pc[g+1])
            );
        end
        for (g = 0; g < SqrtSteps; g++) begin : g_sqrt
            awts_sqrt_cell u_cam_root (
                .i_clk(i_clk), .i_en(1'b1), .i_step(5'(g)),
                .i_d(w_cps[g]), .o_d(w_cps[g+1])
            );
            awts_sqrt_cell u_dist_root (
                .i_clk(i_clk), .i_en(w_en), .i_step(5'(g)),
                .i_d(w_dsq[g]), .o_d(w_dsq[g+1])
            );
            awts_sqrt_cell u_horiz_root (
                .i_clk(i_clk), .i_en(w_en), .i_step(5'(g)),
                .i_d(w_hsq[g]), .o_d(w_hsq[g+1])
            );
        end
        for (g = 0; g < DivSteps; g++) begin : g_div
            awts_div_cell u_div_x (
                .i_clk(i_clk), .i_en(w_en), .i_den(w_f),
                .i_d(w_dvx[g]), .o_d(w_dvx[g+1])
            );
            awts_div_cell u_div_y (
                .i_clk(i_clk), .i_en(w_en), .i_den(w_f),
                .i_d(w_dvy[g]), .o_d(w_dvy[g+1])
            );
        end
    endgenerate

    // ---------------- output register ----------------
    logic signed [36:0] w_qx, w_qy;
    logic [31:0]        r_sx, r_sy, r_dist;
    logic               r_atcam;

    always_comb begin
        w_qx = $signed({1'b0, w_dvx[DivSteps].q});
        w_qy = $signed({1'b0, w_dvy[DivSteps].q});
        if (r_nxdly[DivSteps-1]) begin
            w_qx = ~w_qx;
        end
        if (r_nydly[DivSteps-1]) begin
            w_qy = ~w_qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zdly[ZeroDly-1]) begin
                r_sx    <= 32'd32768;
                r_sy    <= 32'd32768;
                r_dist  <= 32'd0;
                r_atcam <= 1'b1;
            end else begin
                r_sx    <= sat32(w_qx);
                r_sy    <= sat32(w_qy);
                r_dist  <= r_cdly[CarryDly-1] ? 32'hFFFF_FFFF : r_ddly[DistDly-1];
                r_atcam <= 1'b0;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_distance  = r_dist;
    assign o_at_camera = r_atcam;

endmodule

[rtl/awts_checker.sv]
module awts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_screen_x,
    input logic [31:0] o_screen_y,
    input logic [31:0] o_distance,
    input logic        o_at_camera
);

    // A result that is not taken stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_screen_x) && $stable(o_screen_y)
            && $stable(o_distance) && $stable(o_at_camera))
        else $error("result changed while held");

    // An object on the camera lands at the screen center at zero distance.
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_at_camera |-> o_screen_x == 32'h0000_8000
            && o_screen_y == 32'h0000_8000 && o_distance == 32'd0)
        else $error("camera-position result is not centered");

    // The input side only stalls behind a held result.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a held result");

endmodule

bind angular_world_to_screen awts_checker u_awts_checker (.*);
